// File: hdl/permutation_inversion_counter_unit_defines.svh
// Assertion macros shared by the inversion counter RTL.
`ifndef PERMUTATION_INVERSION_COUNTER_UNIT_DEFINES_SVH
`define PERMUTATION_INVERSION_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pic_pkg.sv
// Types and constants of the permutation inversion counter.
package pic_pkg;

  localparam int START_ID_W  = 10;
  localparam int FINISH_ID_W = 10;
  localparam int COUNT_W     = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [START_ID_W-1:0]  start_id;
    logic [FINISH_ID_W-1:0] finish_id;
    logic                   last_pair;
  } pic_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] overtake_count;
    logic               overflowed;
  } pic_result_t;

endpackage

// File: hdl/pic_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module pic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/permutation_inversion_counter_unit.sv
// Permutation inversion counter: counts overtakes between a start and a finish order.
//
// Usage: drive one pair (start id, finish id, last mark) on item and raise start;
// the transaction is taken at a clock edge where start is high and busy is low.
// Each stored pair keeps busy high through the map check state, so a new pair is not
// taken until that check is done. Pairs beyond MAX_N are dropped and flagged.
// After the last pair the block walks all index pairs i<j of the start order through
// a three-stage read pipeline (start store, then finish-position map), one compare
// per cycle, and then drains that pipeline in the drain state before the result.
// The result then sits on result for exactly one cycle with done high; the receiver
// cannot stall and must take it in that cycle.
// After each result, and right after reset, the map is swept clear one entry a cycle,
// all ID_SPACE entries, with busy high. Reset is synchronous: rst clears all control
// state and starts that sweep.
module permutation_inversion_counter_unit
  import pic_pkg::*;
#(
  parameter int MAX_N    = 256,
  parameter int ID_SPACE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  pic_item_t   item,
  output logic        busy,
  output logic        done,
  output pic_result_t result
);

`include "permutation_inversion_counter_unit_defines.svh"

  localparam int SAW   = (MAX_N > 1) ? $clog2(MAX_N) : 1;     // start store address
  localparam int PW    = SAW;                                 // finish position
  localparam int KW    = PW + 1;                              // position + 1, 0 = missing
  localparam int CW    = $clog2(MAX_N + 1);                   // entry count
  localparam int MAW   = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int IDX_W = (MAW > START_ID_W) ? MAW : START_ID_W;
  localparam int MW    = PW + 1;                              // {valid, position}

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP_CHECK,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t state;

  logic [CW-1:0]      cnt;
  logic [COUNT_W-1:0] acc;
  logic               ovf;
  logic [MAW-1:0]     clr_addr;

  // pending map update of the last accepted pair
  logic [MAW-1:0] fid_addr_q;
  logic           fid_inr_q;
  logic [PW-1:0]  pos_q;
  logic           last_q;

  // walk issue counters and pipeline tags
  logic [CW-1:0]  row;
  logic [CW-1:0]  col;
  logic           v1, head1;
  logic           v2, head2, inr2;
  logic [KW-1:0]  key_i;

  // RAM ports
  logic                  start_we;
  logic [SAW-1:0]        start_raddr;
  logic [START_ID_W-1:0] start_rdata;
  logic                  map_we;
  logic [MAW-1:0]        map_waddr;
  logic [MW-1:0]         map_wdata;
  logic [MAW-1:0]        map_raddr;
  logic [MW-1:0]         map_rdata;

  logic                  accept;
  logic [IDX_W-1:0]      fid_ext;
  logic [IDX_W-1:0]      sid_ext;
  logic                  fid_inr;
  logic                  sid_inr;
  logic [KW-1:0]         key2;
  logic                  head0;
  logic                  row_end;
  logic                  walk_end;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  // id range checks and map addresses
  assign fid_ext = IDX_W'(item.finish_id);
  assign sid_ext = IDX_W'(start_rdata);
  assign fid_inr = (32'(item.finish_id) < 32'(ID_SPACE));
  assign sid_inr = (32'(start_rdata) < 32'(ID_SPACE));

  // start store: written on accept, read by the walk
  assign start_we    = accept && (cnt < CW'(MAX_N));
  assign start_raddr = (state == ST_WALK) ? col[SAW-1:0] : cnt[SAW-1:0];

  // map: fid lookup on accept, sid lookup in the walk, writes on check and sweep
  assign map_raddr = v1 ? sid_ext[MAW-1:0] : fid_ext[MAW-1:0];
  assign map_waddr = (state == ST_CLEAR) ? clr_addr : fid_addr_q;
  assign map_wdata = (state == ST_CLEAR) ? '0 : {1'b1, pos_q};
  assign map_we    = (state == ST_CLEAR) ||
                     ((state == ST_MAP_CHECK) && fid_inr_q && !map_rdata[PW]);

  // finish key of the looked-up start id
  assign key2 = (inr2 && map_rdata[PW]) ? ({1'b0, map_rdata[PW-1:0]} + KW'(1)) : '0;

  // walk issue control
  assign head0    = (col == row);
  assign row_end  = (col == cnt - CW'(1));
  assign walk_end = row_end && (row == cnt - CW'(2));

  pic_ram #(
    .WIDTH(START_ID_W),
    .DEPTH(MAX_N)
  ) u_start_store (
    .clk  (clk),
    .we   (start_we),
    .waddr(cnt[SAW-1:0]),
    .wdata(item.start_id),
    .raddr(start_raddr),
    .rdata(start_rdata)
  );

  pic_ram #(
    .WIDTH(MW),
    .DEPTH(ID_SPACE)
  ) u_finish_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  // control, pipeline and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      acc      <= '0;
      ovf      <= 1'b0;
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      done     <= 1'b0;
      row      <= '0;
      col      <= '0;
    end else begin
      done <= 1'b0;

      // read pipeline: start store, then map, then compare
      v1    <= (state == ST_WALK);
      head1 <= head0;
      v2    <= v1;
      head2 <= head1;
      inr2  <= sid_inr;
      if (v2) begin
        if (head2) begin
          key_i <= key2;
        end else if ((key2 < key_i) && (acc != COUNT_MAX)) begin
          acc <= acc + COUNT_W'(1);
        end
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + MAW'(1);
          if (clr_addr == MAW'(ID_SPACE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            last_q <= item.last_pair;
            if (cnt < CW'(MAX_N)) begin
              fid_addr_q <= fid_ext[MAW-1:0];
              fid_inr_q  <= fid_inr;
              pos_q      <= cnt[PW-1:0];
              cnt        <= cnt + CW'(1);
              state      <= ST_MAP_CHECK;
            end else begin
              ovf <= 1'b1;
              if (item.last_pair) begin
                row   <= '0;
                col   <= '0;
                state <= ST_WALK;
              end
            end
          end
        end
        ST_MAP_CHECK: begin
          row <= '0;
          col <= '0;
          if (!last_q) begin
            state <= ST_IDLE;
          end else if (cnt >= CW'(2)) begin
            state <= ST_WALK;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            state <= ST_DRAIN;
          end else if (row_end) begin
            row <= row + CW'(1);
            col <= row + CW'(1);
          end else begin
            col <= col + CW'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            done                  <= 1'b1;
            result.overtake_count <= acc;
            result.overflowed     <= ovf;
            acc                   <= '0;
            ovf                   <= 1'b0;
            cnt                   <= '0;
            clr_addr              <= '0;
            state                 <= ST_CLEAR;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // result comes out just as the map sweep begins
  `PIC_ASSERT_NOW(a_done_starts_sweep, done, (state == ST_CLEAR) && (clr_addr == '0), "result outside sweep start")
  // the read pipeline is empty whenever new pairs can be taken
  `PIC_ASSERT_NOW(a_idle_pipe_empty, state == ST_IDLE, !v1 && !v2, "walk pipeline busy in idle")
  // the map is written only by the pair check or the sweep
  `PIC_ASSERT_NOW(a_map_write_src, map_we, (state == ST_MAP_CHECK) || (state == ST_CLEAR), "stray map write")
  // a stored pair is always followed by its map check
  `PIC_ASSERT_NEXT(a_store_then_check, start_we, (state == ST_MAP_CHECK) && $past(cnt) + CW'(1) == cnt, "missed map check")

endmodule
